// ===== hw/rtl/wast_pkg.sv =====
package wast_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF       = 8;
  localparam int FIRE_WINDOW_DEF = 60;

  // Firings reported by one tick at most
  localparam int MAX_FIRES  = 8;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

  // Field widths
  localparam int MODE_W   = 3;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 6;
  localparam int WEEK_W   = 8;
  localparam int TASK_W   = 16;
  localparam int SEC_W    = 17;
  localparam int WDAY_W   = 3;
  localparam int STATUS_W = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  // Time constants
  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int SECS_PER_HOUR = 60 * 60;
  localparam int DAYS_PER_WEEK = 7;

  localparam logic [WEEK_W-1:0] TODAY_ONLY = 8'h80;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_SET    = 3'd2,
    MODE_OPEN   = 3'd3,
    MODE_CLOSE  = 3'd4,
    MODE_DELETE = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_REPEAT   = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_BAD_TIME = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TGT,
    S_PRIME,
    S_SCAN,
    S_TICK_END,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the request
    logic rd_tgt;      // read the target slot
    logic scan_start;  // clear scan state, read slot zero
    logic scan_step;   // evaluate the slot on the read port
    logic tick_end;    // emit the final tick result
    logic finish;      // apply the command and emit its result
  } wast_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              time_bad;
    logic              id_bad;
    logic              scan_last;
    logic              stall;
    logic              out_free;
  } wast_stat_t;

endpackage

// ===== hw/rtl/wast_ram.sv =====
module wast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/wast_ctrl.sv =====
module wast_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  wast_pkg::wast_stat_t stat,
  output wast_pkg::wast_cmd_t  cmd
);

  import wast_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode) inside
          MODE_TICK: state_next = S_PRIME;
          MODE_ADD:  state_next = stat.time_bad ? S_FINISH : S_PRIME;
          MODE_SET:  state_next = (stat.time_bad || stat.id_bad) ? S_FINISH : S_TGT;
          default:   state_next = S_FINISH;
        endcase
      end
      S_TGT: begin
        cmd.rd_tgt = 1'b1;
        state_next = S_PRIME;
      end
      S_PRIME: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!stat.stall && stat.scan_last) begin
          state_next = (stat.mode == MODE_TICK) ? S_TICK_END : S_FINISH;
        end
      end
      S_TICK_END: begin
        if (stat.out_free) begin
          cmd.tick_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/wast_dp.sv =====
module wast_dp #(
  parameter int SLOTS       = wast_pkg::SLOTS_DEF,
  parameter int FIRE_WINDOW = wast_pkg::FIRE_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wast_pkg::wast_cmd_t           cmd,
  output wast_pkg::wast_stat_t          stat,
  input  logic                          fire_enable,
  input  logic [wast_pkg::MODE_W-1:0]   in_mode,
  input  logic [wast_pkg::ID_W-1:0]     in_slot_id,
  input  logic [wast_pkg::TIME_W-1:0]   in_hour,
  input  logic [wast_pkg::TIME_W-1:0]   in_minute,
  input  logic [wast_pkg::TIME_W-1:0]   in_second,
  input  logic [wast_pkg::WEEK_W-1:0]   in_week_mask,
  input  logic [wast_pkg::TASK_W-1:0]   in_task_tag,
  input  logic [wast_pkg::SEC_W-1:0]    in_second_of_day,
  input  logic [wast_pkg::WDAY_W-1:0]   in_weekday,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wast_pkg::STATUS_W-1:0] out_status,
  output logic [wast_pkg::ID_W-1:0]     out_slot_index,
  output logic                          out_fired,
  output logic [wast_pkg::TASK_W-1:0]   out_fired_task,
  output logic                          out_last
);

  import wast_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W = SEC_W + 1;
  localparam int REC_W = SEC_W + TASK_W;

  // Captured request
  logic [MODE_W-1:0] mode_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] hour_q, min_q, sec_q;
  logic [WEEK_W-1:0] wk_q;
  logic [TASK_W-1:0] tag_q;
  logic [SEC_W-1:0]  now_q;
  logic [WDAY_W-1:0] wday_q;

  // Slot storage
  logic [SLOTS-1:0]  enabled, armed, wk_vld, rec_vld;
  logic              wk_rv, rec_rv;
  logic [WEEK_W-1:0] wk_raw, wk_wdata, rd_wk;
  logic [REC_W-1:0]  rec_raw, rec_wdata;
  logic [SEC_W-1:0]  rd_sec;
  logic [TASK_W-1:0] rd_task;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              wk_we, rec_we;

  // Scan state
  logic [IDX_W-1:0]      scan_idx, scan_nxt, tgt, free_idx, pend_idx;
  logic                  scan_last, step_go, stall;
  logic                  dup, free_fnd, pend_vld;
  logic [FIRE_CNT_W-1:0] fire_cnt;
  logic [TASK_W-1:0]     pend_task, tgt_task;

  // Derived request values
  logic [SEC_W-1:0]  secs_in;
  logic              time_bad, id_bad;
  logic              is_tick, is_add, is_set;

  // Tick evaluation
  logic              midnight, today, ar_eff, en_eff, in_win, day_ok, fire;
  logic              ar_new, en_new;
  logic [WEEK_W-1:0] daybit;
  logic [SUM_W-1:0]  win_hi;

  // Completion
  status_t           fin_status;
  logic              add_ok, set_ok, out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= in_mode;
      id_q   <= in_slot_id;
      hour_q <= in_hour;
      min_q  <= in_minute;
      sec_q  <= in_second;
      wk_q   <= in_week_mask;
      tag_q  <= in_task_tag;
      now_q  <= in_second_of_day;
      wday_q <= in_weekday;
    end
  end

  assign secs_in = SEC_W'(hour_q) * SEC_W'(SECS_PER_HOUR)
                 + SEC_W'(min_q) * SEC_W'(SECS_PER_MIN) + SEC_W'(sec_q);
  assign time_bad = (hour_q >= TIME_W'(HOURS_PER_DAY)) || (min_q >= TIME_W'(MINS_PER_HOUR))
                 || (sec_q >= TIME_W'(SECS_PER_MIN));
  assign id_bad  = {1'b0, id_q} >= (ID_W + 1)'(SLOTS);
  assign tgt     = id_q[IDX_W-1:0];
  assign is_tick = mode_q == MODE_TICK;
  assign is_add  = mode_q == MODE_ADD;
  assign is_set  = mode_q == MODE_SET;

  // Read port: target slot, or walk the slots in order; hold the address on a stall
  assign scan_last = scan_idx == IDX_W'(SLOTS - 1);
  assign scan_nxt  = scan_last ? '0 : scan_idx + 1'b1;

  always_comb begin
    if (cmd.rd_tgt) begin
      rd_addr = tgt;
    end else if (cmd.scan_step) begin
      rd_addr = stall ? scan_idx : scan_nxt;
    end else begin
      rd_addr = '0;
    end
  end

  wast_ram #(.WIDTH(WEEK_W), .DEPTH(SLOTS)) u_week_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wr_addr),
    .wdata (wk_wdata),
    .raddr (rd_addr),
    .rdata (wk_raw)
  );

  wast_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (wr_addr),
    .wdata (rec_wdata),
    .raddr (rd_addr),
    .rdata (rec_raw)
  );

  // Never-written entries read as zero (free slot)
  assign rd_wk   = wk_rv ? wk_raw : '0;
  assign rd_sec  = rec_rv ? rec_raw[SEC_W-1:0] : '0;
  assign rd_task = rec_rv ? rec_raw[REC_W-1:SEC_W] : '0;

  // Tick: midnight re-arm and today-only close folded into the per-slot step
  assign midnight = now_q == '0;
  assign daybit   = (wday_q < WDAY_W'(DAYS_PER_WEEK)) ? (WEEK_W'(1) << wday_q) : '0;
  assign today    = rd_wk == TODAY_ONLY;
  assign ar_eff   = armed[scan_idx] | midnight;
  assign en_eff   = enabled[scan_idx] & ~(midnight & today);
  assign win_hi   = SUM_W'(rd_sec) + SUM_W'(FIRE_WINDOW);
  assign in_win   = (rd_wk != '0) && en_eff && ar_eff && (now_q >= rd_sec)
                 && (SUM_W'(now_q) <= win_hi);
  assign day_ok   = ((rd_wk & daybit) != '0) || today;
  assign fire     = cmd.scan_step && is_tick && in_win && day_ok && fire_enable
                 && (fire_cnt < FIRE_CNT_W'(MAX_FIRES));
  assign ar_new   = (in_win && (fire || !day_ok)) ? 1'b0 : ar_eff;
  assign en_new   = (fire && today) ? 1'b0 : en_eff;

  assign out_free = !out_valid || out_ready;
  assign stall    = fire && pend_vld && !out_free;
  assign step_go  = cmd.scan_step && !stall;

  always_comb begin
    unique case (mode_q) inside
      MODE_ADD: begin
        if (time_bad)       fin_status = ST_BAD_TIME;
        else if (dup)       fin_status = ST_REPEAT;
        else if (!free_fnd) fin_status = ST_FULL;
        else                fin_status = ST_OK;
      end
      MODE_SET: begin
        if (time_bad)       fin_status = ST_BAD_TIME;
        else if (id_bad)    fin_status = ST_NO_SLOT;
        else if (dup)       fin_status = ST_REPEAT;
        else                fin_status = ST_OK;
      end
      MODE_OPEN, MODE_CLOSE, MODE_DELETE: begin
        fin_status = id_bad ? ST_NO_SLOT : ST_OK;
      end
      default: fin_status = ST_OK;
    endcase
  end

  assign add_ok    = is_add && (fin_status == ST_OK);
  assign set_ok    = is_set && (fin_status == ST_OK);
  assign wr_addr   = is_add ? free_idx : tgt;
  assign wk_we     = cmd.finish && (add_ok || set_ok || (mode_q == MODE_DELETE && !id_bad));
  assign wk_wdata  = (mode_q == MODE_DELETE) ? '0 : wk_q;
  assign rec_we    = cmd.finish && (add_ok || set_ok);
  assign rec_wdata = is_add ? {tag_q, secs_in} : {tgt_task, secs_in};

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= '0;
      armed     <= '0;
      wk_vld    <= '0;
      rec_vld   <= '0;
      wk_rv     <= 1'b0;
      rec_rv    <= 1'b0;
      scan_idx  <= '0;
      dup       <= 1'b0;
      free_fnd  <= 1'b0;
      pend_vld  <= 1'b0;
      fire_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      wk_rv  <= wk_vld[rd_addr];
      rec_rv <= rec_vld[rd_addr];
      if (wk_we) begin
        wk_vld[wr_addr] <= 1'b1;
      end
      if (rec_we) begin
        rec_vld[wr_addr] <= 1'b1;
      end

      if (cmd.scan_start) begin
        scan_idx <= '0;
        dup      <= 1'b0;
        free_fnd <= 1'b0;
        pend_vld <= 1'b0;
        fire_cnt <= '0;
      end else if (step_go) begin
        if (!scan_last) begin
          scan_idx <= scan_nxt;
        end
        if (is_add) begin
          if (rd_sec == secs_in && rd_wk == wk_q && rd_task == tag_q) dup <= 1'b1;
          if (!free_fnd && rd_wk == '0) free_fnd <= 1'b1;
        end
        if (is_set && rd_sec == secs_in && rd_task == tgt_task) begin
          dup <= 1'b1;
        end
        if (is_tick) begin
          enabled[scan_idx] <= en_new;
          armed[scan_idx]   <= ar_new;
          if (fire) begin
            pend_vld <= 1'b1;
            fire_cnt <= fire_cnt + 1'b1;
          end
        end
      end

      if (cmd.finish) begin
        case (mode_q) inside
          MODE_ADD: begin
            if (add_ok) begin
              enabled[free_idx] <= 1'b1;
              armed[free_idx]   <= 1'b1;
            end
          end
          MODE_SET: begin
            if (set_ok) armed[tgt] <= 1'b1;
          end
          MODE_OPEN: begin
            if (!id_bad) begin
              enabled[tgt] <= 1'b1;
              armed[tgt]   <= 1'b1;
            end
          end
          MODE_CLOSE: begin
            if (!id_bad) enabled[tgt] <= 1'b0;
          end
          MODE_DELETE: begin
            if (!id_bad) begin
              enabled[tgt] <= 1'b0;
              armed[tgt]   <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if ((step_go && fire && pend_vld) || cmd.tick_end || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan payload and output register
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      tgt_task <= rd_task;
    end
    if (step_go && is_add && !free_fnd && rd_wk == '0) begin
      free_idx <= scan_idx;
    end
    if (step_go && fire) begin
      pend_idx  <= scan_idx;
      pend_task <= rd_task;
    end

    if (step_go && fire && pend_vld) begin
      out_status     <= ST_OK;
      out_slot_index <= ID_W'(pend_idx);
      out_fired      <= 1'b1;
      out_fired_task <= pend_task;
      out_last       <= 1'b0;
    end else if (cmd.tick_end) begin
      out_status     <= ST_OK;
      out_slot_index <= pend_vld ? ID_W'(pend_idx) : '0;
      out_fired      <= pend_vld;
      out_fired_task <= pend_vld ? pend_task : '0;
      out_last       <= 1'b1;
    end else if (cmd.finish) begin
      out_status     <= fin_status;
      out_slot_index <= add_ok ? ID_W'(free_idx) : '0;
      out_fired      <= 1'b0;
      out_fired_task <= '0;
      out_last       <= 1'b1;
    end
  end

  assign stat.mode      = mode_q;
  assign stat.time_bad  = time_bad;
  assign stat.id_bad    = id_bad;
  assign stat.scan_last = scan_last;
  assign stat.stall     = stall;
  assign stat.out_free  = out_free;

endmodule

// ===== hw/rtl/weekly_alarm_slot_table_core.sv =====
// Sequence: each request is decoded; set then reads its target slot; add, set and tick
//   walk every slot in order before completing, while open, close, delete and rejected
//   add/set complete right after decode. A new request is taken only once the previous
//   result is registered; the walk over the slots goes through the single read
//   port of the slot memories. A result waits on m_tready, and a tick with several
//   firings also waits on m_tready for each result past the first.
// Reset (rst, synchronous): every slot reads as free at once through per-slot valid bits,
//   and is closed and disarmed, no clearing pass; fire_enable returns to 1.
module weekly_alarm_slot_table_core #(
  parameter int SLOTS       = wast_pkg::SLOTS_DEF,
  parameter int FIRE_WINDOW = wast_pkg::FIRE_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] slot_id, [13:8] alarm_hour, [19:14] alarm_minute, [25:20] alarm_second,
  // [33:26] week_mask, [49:34] task_tag, [66:50] second_of_day, [69:67] weekday
  input  logic [wast_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [2:0] mode
  input  logic [wast_pkg::MODE_W-1:0]         s_tuser,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] status, [10:3] slot_index, [26:11] fired_task
  output logic [wast_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // [0] fired
  output logic                                m_tuser,
  output logic                                m_tlast,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  import wast_pkg::*;

  // Register index, taken from paddr[2] (one 32-bit register at byte address 0)
  localparam logic REG_FIRE_ENABLE = 1'b0;

  logic       fire_enable;
  wast_cmd_t  cmd;
  wast_stat_t stat;

  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_slot_index;
  logic [TASK_W-1:0]   out_fired_task;

  // fire_enable: 0 holds matching slots armed and silent
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_enable <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_FIRE_ENABLE) begin
      fire_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_FIRE_ENABLE) ? {31'b0, fire_enable} : '0;

  // Controller: sequences decode, target read, slot walk and completion
  wast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: request capture, slot memories, per-slot checks, result register
  wast_dp #(.SLOTS(SLOTS), .FIRE_WINDOW(FIRE_WINDOW)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .fire_enable      (fire_enable),
    .in_mode          (s_tuser),
    .in_slot_id       (s_tdata[7:0]),
    .in_hour          (s_tdata[13:8]),
    .in_minute        (s_tdata[19:14]),
    .in_second        (s_tdata[25:20]),
    .in_week_mask     (s_tdata[33:26]),
    .in_task_tag      (s_tdata[49:34]),
    .in_second_of_day (s_tdata[66:50]),
    .in_weekday       (s_tdata[69:67]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_fired        (m_tuser),
    .out_fired_task   (out_fired_task),
    .out_last         (m_tlast)
  );

  // Pack the result; pad the upper bits with zeros
  assign m_tdata = {5'b0, out_fired_task, out_slot_index, out_status};

endmodule
